// ===== rtl/core/thri_pkg.sv =====
// shared types, codes and constants for the timed history ring interpolator
package thri_pkg;

    // default sizes of the stores
    localparam int MAX_SNAPSHOTS_DEF = 8;
    localparam int MAX_VECTOR_DEF    = 16;

    // register reset values
    localparam int VEC_LEN_RST = 16;
    localparam int DEPTH_RST   = 8;

    // fixed field widths
    localparam int VL_W    = 5;
    localparam int DL_W    = 4;
    localparam int CNT_W   = 4;
    localparam int ALPHA_W = 17;
    localparam int FRAC_W  = 16;

    // register bus
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes
    typedef enum logic [1:0] {
        REG_VEC_LEN = 2'd0,
        REG_DEPTH   = 2'd1,
        REG_INTERP  = 2'd2,
        REG_NONE    = 2'd3
    } t_reg_idx;

    // commands
    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_READ   = 3'd3,
        CMD_FIND   = 3'd4,
        CMD_INTERP = 3'd5,
        CMD_RSV6   = 3'd6,
        CMD_RSV7   = 3'd7
    } t_cmd;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_DISABLED = 3'd3,
        ST_TOO_FEW  = 3'd4,
        ST_OUTSIDE  = 3'd5,
        ST_SIZE     = 3'd6,
        ST_RSV7     = 3'd7
    } t_status;

    // input beat
    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] time_value;
        logic [30:0]        tolerance;
        logic [2:0]         steps_back;
        logic signed [31:0] element_value;
        logic               last_element;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] sample_value;
        logic signed [31:0] snapshot_time;
        logic [2:0]         found_index;
        logic               found;
        logic [3:0]         held_count;
        logic               last_result;
    } t_out_beat;

    // divider request
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

endpackage

// ===== rtl/core/thri_div.sv =====
// iterative restoring divider for the interpolation weight, one quotient bit a cycle
module thri_div import thri_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic [ALPHA_W-1:0] o_quot
);

    localparam int CW = $clog2(ALPHA_W + 1);

    logic [32:0]        r_rem;
    logic [31:0]        r_den;
    logic [ALPHA_W-1:0] r_quot;
    logic [CW-1:0]      r_cnt;
    logic               r_done;
    logic               ge;
    logic [32:0]        n_rem;

    // one compare and subtract step
    always_comb begin
        ge    = r_rem >= {1'b0, r_den};
        n_rem = ge ? (r_rem - {1'b0, r_den}) : r_rem;
    end

    // bit sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= CW'(ALPHA_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {1'b0, i_req.num};
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= {n_rem[31:0], 1'b0};
            r_quot <= {r_quot[ALPHA_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/core/thri_smem.sv =====
// sample store: one write port, two registered read ports
module thri_smem import thri_pkg::*; #(
    parameter int DEPTH = MAX_SNAPSHOTS_DEF * MAX_VECTOR_DEF,
    parameter int AW    = $clog2(MAX_SNAPSHOTS_DEF * MAX_VECTOR_DEF)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [31:0] i_wdata,
    input  logic [AW-1:0]      i_raddr_a,
    input  logic [AW-1:0]      i_raddr_b,
    output logic signed [31:0] o_rdata_a,
    output logic signed [31:0] o_rdata_b
);

    logic signed [31:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

// ===== rtl/core/timed_history_ring_interpolator.sv =====
// top level: register port, command sequencer, time and staging stores
// Keeps up to depth_limit time-stamped vectors newest first and serves push, pop, clear,
// read, find and interpolate commands; one command is taken at a time and input stall stays
// high until the sequencer is back in idle. Per command: a push element that is not last
// goes into the staging row; a committing push copies the staging row into the sample store
// element by element, a staging read and then a store write each; pop, clear and errors give
// one beat; read gives vector_length beats, each through the address, multiply and output
// states; find walks the snapshots one by one over the single time store read port;
// interpolate walks pairs, runs the bit-serial divider for the weight, then gives one beat
// per element through the multiplier. No clearing pass is needed after reset.
module timed_history_ring_interpolator import thri_pkg::*; #(
    parameter int MAX_SNAPSHOTS = MAX_SNAPSHOTS_DEF,
    parameter int MAX_VECTOR    = MAX_VECTOR_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_beat           i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_beat          o_out_data,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int SW    = (MAX_SNAPSHOTS > 1) ? $clog2(MAX_SNAPSHOTS) : 1;
    localparam int JW    = (MAX_VECTOR > 1) ? $clog2(MAX_VECTOR) : 1;
    localparam int FW    = $clog2(MAX_VECTOR + 2);
    localparam int DEPTH = MAX_SNAPSHOTS * MAX_VECTOR;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VL_RST_V = (VEC_LEN_RST > MAX_VECTOR) ? MAX_VECTOR : VEC_LEN_RST;
    localparam int DL_RST_V = (DEPTH_RST > MAX_SNAPSHOTS) ? MAX_SNAPSHOTS : DEPTH_RST;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_COPY_RD = 10'b0000000010,
        S_COPY_WR = 10'b0000000100,
        S_SCAN_A  = 10'b0000001000,
        S_SCAN_B  = 10'b0000010000,
        S_DIV     = 10'b0000100000,
        S_EADDR   = 10'b0001000000,
        S_EMUL    = 10'b0010000000,
        S_EOUT    = 10'b0100000000,
        S_RESP    = 10'b1000000000
    } t_state;

    // slot that lies a number of steps back from the newest
    function automatic logic [SW-1:0] slot_back(input logic [SW-1:0] newest,
                                                input logic [2:0] back);
        int b;
        int s;
        b = int'(back);
        for (int k = 0; k < 8; k++) begin
            if (b >= MAX_SNAPSHOTS) begin
                b = b - MAX_SNAPSHOTS;
            end
        end
        s = int'(newest) - b;
        if (s < 0) begin
            s = s + MAX_SNAPSHOTS;
        end
        return SW'(s);
    endfunction

    // one slot older, with wrap
    function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s);
        return (s == '0) ? SW'(MAX_SNAPSHOTS - 1) : (s - 1'b1);
    endfunction

    // one slot newer, with wrap
    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (int'(s) == MAX_SNAPSHOTS - 1) ? '0 : (s + 1'b1);
    endfunction

    // configuration
    logic [VL_W-1:0]  r_vec_len;
    logic [DL_W-1:0]  r_depth;
    logic             r_interp_en;

    // ring state
    t_state           r_state;
    logic [SW-1:0]    r_newest;
    logic [CNT_W-1:0] r_count;
    logic [FW-1:0]    r_fill;
    logic [SW-1:0]    n_newest;
    logic [CNT_W-1:0] n_count;
    logic [FW-1:0]    n_fill;

    // stores kept here
    logic signed [31:0] time_store [MAX_SNAPSHOTS];
    logic signed [31:0] staging [MAX_VECTOR];
    logic signed [31:0] r_trd;
    logic signed [31:0] r_stg_rd;

    // command context
    logic [2:0]         r_cmd;
    logic signed [31:0] r_t;
    logic [30:0]        r_tol;
    logic [CNT_W-1:0]   r_i;
    logic [SW-1:0]      r_scan_slot;
    logic [SW-1:0]      r_sa;
    logic [SW-1:0]      r_sb;
    logic signed [31:0] r_tprev;
    logic [SW-1:0]      r_prev_slot;
    logic [JW-1:0]      r_j;
    logic               r_dt_pos;
    logic signed [50:0] r_prod;
    t_out_beat          r_resp;

    // output register
    logic               r_out_valid;
    t_out_beat          r_out;
    logic               out_free;

    // shared units
    t_div_req           div_req;
    logic               div_done;
    logic [ALPHA_W-1:0] alpha;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr_a;
    logic [AW-1:0]      mem_raddr_b;
    logic signed [31:0] mem_rda;
    logic signed [31:0] mem_rdb;

    // decode helpers
    logic               in_acc;
    logic               cfg_wr;
    logic [VL_W-1:0]    cfg_vl;
    logic [DL_W-1:0]    cfg_dl;
    logic               last_j;
    logic               last_i;
    logic signed [32:0] tdiff;
    logic [32:0]        tabs;
    logic               t_hit;
    logic               pair_hit;
    logic signed [32:0] vdiff;
    logic signed [31:0] interp_val;
    t_out_beat          elem_beat;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;

    // register write values, clamped to the supported range
    always_comb begin
        cfg_vl = pwdata[VL_W-1:0];
        if (cfg_vl == '0) begin
            cfg_vl = VL_W'(1);
        end
        if (int'(cfg_vl) > MAX_VECTOR) begin
            cfg_vl = VL_W'(MAX_VECTOR);
        end
        cfg_dl = pwdata[DL_W-1:0];
        if (int'(cfg_dl) > MAX_SNAPSHOTS) begin
            cfg_dl = DL_W'(MAX_SNAPSHOTS);
        end
    end

    // register read back
    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_VEC_LEN: prdata = PDATA_W'(r_vec_len);
            REG_DEPTH:   prdata = PDATA_W'(r_depth);
            REG_INTERP:  prdata = PDATA_W'(r_interp_en);
            default:     prdata = '0;
        endcase
    end

    // push bookkeeping for the accepted beat
    always_comb begin
        n_fill   = r_fill;
        n_newest = r_newest;
        n_count  = r_count;
        if (int'(r_fill) <= MAX_VECTOR) begin
            n_fill = r_fill + 1'b1;
        end
        if (r_count != '0) begin
            n_newest = slot_inc(r_newest);
        end
        if (r_count < CNT_W'(r_depth)) begin
            n_count = r_count + 1'b1;
        end
    end

    // loop end flags
    assign last_j = ((VL_W + 1)'(r_j) + 1'b1) == (VL_W + 1)'(r_vec_len);
    assign last_i = (r_i + 1'b1) == r_count;

    // time compare for find and interpolate
    always_comb begin
        tdiff    = 33'(r_trd) - 33'(r_t);
        tabs     = tdiff[32] ? 33'(-tdiff) : 33'(tdiff);
        t_hit    = tabs <= {2'b00, r_tol};
        pair_hit = (r_tprev >= r_t) && (r_t >= r_trd);
    end

    // element value for read and interpolate
    always_comb begin
        vdiff      = 33'(mem_rda) - 33'(mem_rdb);
        interp_val = r_dt_pos ? (mem_rdb + 32'(r_prod >>> FRAC_W)) : mem_rdb;
        elem_beat               = '0;
        elem_beat.status        = ST_OK;
        elem_beat.sample_value  = (r_cmd == CMD_INTERP) ? interp_val : mem_rda;
        elem_beat.snapshot_time = (r_cmd == CMD_INTERP) ? 32'sd0 : r_trd;
        elem_beat.held_count    = r_count;
        elem_beat.last_result   = last_j;
    end

    // sample store addressing
    assign mem_we      = (r_state == S_COPY_WR);
    assign mem_waddr   = AW'(int'(r_newest) * MAX_VECTOR) + AW'(r_j);
    assign mem_raddr_a = AW'(int'(r_sa) * MAX_VECTOR) + AW'(r_j);
    assign mem_raddr_b = AW'(int'(r_sb) * MAX_VECTOR) + AW'(r_j);

    // divider request on a bracketing hit
    always_comb begin
        div_req.start = (r_state == S_SCAN_B) && (r_cmd == CMD_INTERP) && (r_i != '0)
                        && pair_hit;
        div_req.num   = 32'(r_t - r_trd);
        div_req.den   = 32'(r_tprev - r_trd);
    end

    thri_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (alpha)
    );

    thri_smem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_smem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (r_stg_rd),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rda),
        .o_rdata_b (mem_rdb)
    );

    // time store and staging row
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.command == CMD_PUSH)) begin
            if (int'(r_fill) < MAX_VECTOR) begin
                staging[JW'(r_fill)] <= i_in_data.element_value;
            end
            if (i_in_data.last_element && (int'(n_fill) == int'(r_vec_len))
                && (r_depth != '0)) begin
                time_store[n_newest] <= i_in_data.time_value;
            end
        end
        r_trd    <= time_store[r_scan_slot];
        r_stg_rd <= staging[r_j];
    end

    // weighted difference
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMUL) begin
            r_prod <= 51'(vdiff * $signed({1'b0, alpha}));
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vec_len   <= VL_W'(VL_RST_V);
            r_depth     <= DL_W'(DL_RST_V);
            r_interp_en <= 1'b1;
            r_newest    <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // register writes to the three used indexes reset the ring
            if (cfg_wr) begin
                unique case (t_reg_idx'(paddr[3:2]))
                    REG_VEC_LEN: r_vec_len   <= cfg_vl;
                    REG_DEPTH:   r_depth     <= cfg_dl;
                    REG_INTERP:  r_interp_en <= pwdata[0];
                    default:     ;
                endcase
                if (t_reg_idx'(paddr[3:2]) != REG_NONE) begin
                    r_newest <= '0;
                    r_count  <= '0;
                    r_fill   <= '0;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd       <= i_in_data.command;
                        r_t         <= i_in_data.time_value;
                        r_tol       <= i_in_data.tolerance;
                        r_resp      <= '0;
                        r_resp.last_result <= 1'b1;
                        r_i         <= '0;
                        r_j         <= '0;
                        r_scan_slot <= r_newest;
                        unique case (t_cmd'(i_in_data.command))
                            CMD_PUSH: begin
                                r_fill <= n_fill;
                                if (i_in_data.last_element) begin
                                    r_fill <= '0;
                                    if (int'(n_fill) != int'(r_vec_len)) begin
                                        r_resp.status <= ST_SIZE;
                                        r_state       <= S_RESP;
                                    end else if (r_depth != '0) begin
                                        r_newest <= n_newest;
                                        r_count  <= n_count;
                                        r_state  <= S_COPY_RD;
                                    end else begin
                                        r_state <= S_RESP;
                                    end
                                end
                            end
                            CMD_POP: begin
                                if (r_count == '0) begin
                                    r_resp.status <= ST_EMPTY;
                                end else begin
                                    r_newest <= slot_dec(r_newest);
                                    r_count  <= r_count - 1'b1;
                                end
                                r_state <= S_RESP;
                            end
                            CMD_CLEAR: begin
                                r_newest <= '0;
                                r_count  <= '0;
                                r_state  <= S_RESP;
                            end
                            CMD_READ: begin
                                if (CNT_W'(i_in_data.steps_back) >= r_count) begin
                                    r_resp.status <= ST_RANGE;
                                    r_state       <= S_RESP;
                                end else begin
                                    r_sa        <= slot_back(r_newest, i_in_data.steps_back);
                                    r_scan_slot <= slot_back(r_newest, i_in_data.steps_back);
                                    r_state     <= S_EADDR;
                                end
                            end
                            CMD_FIND: begin
                                r_state <= (r_count == '0) ? S_RESP : S_SCAN_A;
                            end
                            CMD_INTERP: begin
                                if (!r_interp_en) begin
                                    r_resp.status <= ST_DISABLED;
                                    r_state       <= S_RESP;
                                end else if (r_count < CNT_W'(2)) begin
                                    r_resp.status <= ST_TOO_FEW;
                                    r_state       <= S_RESP;
                                end else begin
                                    r_state <= S_SCAN_A;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // staging row into the sample store
                S_COPY_RD: begin
                    r_state <= S_COPY_WR;
                end
                S_COPY_WR: begin
                    if (last_j) begin
                        r_state <= S_RESP;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_COPY_RD;
                    end
                end

                // time store walk, one snapshot per pass
                S_SCAN_A: begin
                    r_state <= S_SCAN_B;
                end
                S_SCAN_B: begin
                    if (r_cmd == CMD_FIND) begin
                        if (t_hit) begin
                            r_resp.found         <= 1'b1;
                            r_resp.found_index   <= r_i[2:0];
                            r_resp.snapshot_time <= r_trd;
                            r_state              <= S_RESP;
                        end else if (last_i) begin
                            r_state <= S_RESP;
                        end else begin
                            r_i         <= r_i + 1'b1;
                            r_scan_slot <= slot_dec(r_scan_slot);
                            r_state     <= S_SCAN_A;
                        end
                    end else begin
                        if ((r_i != '0) && pair_hit) begin
                            r_sa     <= r_prev_slot;
                            r_sb     <= r_scan_slot;
                            r_dt_pos <= (r_tprev != r_trd);
                            r_state  <= S_DIV;
                        end else if (last_i) begin
                            r_resp.status <= ST_OUTSIDE;
                            r_state       <= S_RESP;
                        end else begin
                            r_tprev     <= r_trd;
                            r_prev_slot <= r_scan_slot;
                            r_i         <= r_i + 1'b1;
                            r_scan_slot <= slot_dec(r_scan_slot);
                            r_state     <= S_SCAN_A;
                        end
                    end
                end

                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_EADDR;
                    end
                end

                // element loop for read and interpolate
                S_EADDR: begin
                    r_state <= S_EMUL;
                end
                S_EMUL: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= elem_beat;
                        if (last_j) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_EADDR;
                        end
                    end
                end

                // single result beat
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out             <= r_resp;
                        r_out.held_count  <= r_count;
                        r_state           <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
